/* design/sfd_pkg.sv */
// ---------------------------------------------------------------------------
// sfd_pkg: shared types, constants and width helpers
// Holds the status codes, the control word that travels beside the data and
// the functions that size the internal words from the time format.
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int DEF_TIME_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int MANT_FRAC = 30;
  localparam int MANT_W    = MANT_FRAC + 1;
  localparam int LOG_FRAC  = 32;
  localparam int LN_FRAC   = 20;
  localparam int LN2_W     = 24;
  localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
  // The ln2 product carries LOG_FRAC + 24 fraction bits; LN_FRAC are kept.
  localparam int LN_DROP   = LOG_FRAC + LN2_W - LN_FRAC;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_e;

  typedef struct packed {
    logic    zero;
    status_e code;
  } sfd_ctrl_t;

  localparam int CTRL_W = $bits(sfd_ctrl_t);

  function automatic int int_width(input int tw, input int fb);
    return $clog2(tw + fb + 2) + 1;
  endfunction

  function automatic int lg_width(input int tw, input int fb);
    return int_width(tw, fb) + LOG_FRAC;
  endfunction

  function automatic int ln_width(input int tw, input int fb);
    return lg_width(tw, fb) + 1 + LN2_W + 1 - LN_DROP;
  endfunction

  function automatic int sh_pos(input int fb);
    return (LN_FRAC > fb) ? (LN_FRAC - fb) : 0;
  endfunction

  function automatic int sh_neg(input int fb);
    return (fb > LN_FRAC) ? (fb - LN_FRAC) : 0;
  endfunction

  function automatic int n_width(input int tw, input int fb);
    int pw;
    int a;
    int b;
    pw = tw + 1 + ln_width(tw, fb);
    a  = pw + sh_neg(fb);
    b  = tw + 1 + sh_pos(fb);
    return ((a > b) ? a : b) + 1;
  endfunction

  function automatic int d_width(input int tw, input int fb);
    return tw + 2 + sh_pos(fb);
  endfunction

endpackage

/* design/sfd_delay.sv */
// ---------------------------------------------------------------------------
// sfd_delay: valid and side data delay line
// Carries a valid bit and a side word through a fixed number of stages that
// advance together with the data path.
// ---------------------------------------------------------------------------
module sfd_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic         v_q [DEPTH];
  logic [W-1:0] d_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) d_q[i] <= d_q[i-1];
    end
  end

  assign valid_o = v_q[DEPTH-1];
  assign data_o  = d_q[DEPTH-1];

endmodule

/* design/sfd_log2.sv */
// ---------------------------------------------------------------------------
// sfd_log2: pipelined fixed-point base-2 logarithm
// A staged leading-one normaliser followed by one squaring stage per
// fraction bit of the result.
// ---------------------------------------------------------------------------
module sfd_log2 import sfd_pkg::*; #(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  localparam int VW  = TIME_WIDTH + 1,
  localparam int LGW = lg_width(TIME_WIDTH, FRAC_BITS)
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [VW-1:0]         arg_i,
  output logic signed [LGW-1:0] log_o
);

  localparam int SCW = $clog2(VW);
  localparam int IW  = int_width(TIME_WIDTH, FRAC_BITS);
  localparam int OFF = TIME_WIDTH - FRAC_BITS - 1;

  logic [VW-1:0]  nv_q [SCW];
  logic [SCW-1:0] ns_q [SCW];
  logic           nz_q [SCW];

  for (genvar j = 0; j < SCW; j++) begin : g_norm
    localparam int AMT = 1 << (SCW - 1 - j);
    logic [VW-1:0]  v_in;
    logic [SCW-1:0] s_in;
    logic           z_in;
    if (j == 0) begin : g_first
      assign v_in = arg_i;
      assign s_in = '0;
      assign z_in = (arg_i == '0);
    end else begin : g_next
      assign v_in = nv_q[j-1];
      assign s_in = ns_q[j-1];
      assign z_in = nz_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in[VW-1 -: AMT] == '0) begin
          nv_q[j] <= v_in << AMT;
          ns_q[j] <= s_in + SCW'(AMT);
        end else begin
          nv_q[j] <= v_in;
          ns_q[j] <= s_in;
        end
        nz_q[j] <= z_in;
      end
    end
  end

  logic [VW+MANT_W-1:0] ext;
  assign ext = {nv_q[SCW-1], {MANT_W{1'b0}}};

  logic [MANT_W-1:0]      y_q  [LOG_FRAC];
  logic [LOG_FRAC-1:0]    fr_q [LOG_FRAC];
  logic signed [IW-1:0]   ip_q [LOG_FRAC];
  logic                   sz_q [LOG_FRAC];

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
    logic [MANT_W-1:0]   y_in;
    logic [LOG_FRAC-1:0] fr_in;
    logic [IW-1:0]       ip_in;
    logic                z_in;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    if (i == 0) begin : g_first
      assign y_in  = ext[VW+MANT_W-1 -: MANT_W];
      assign fr_in = '0;
      assign ip_in = IW'(OFF) - IW'(ns_q[SCW-1]);
      assign z_in  = nz_q[SCW-1];
    end else begin : g_next
      assign y_in  = y_q[i-1];
      assign fr_in = fr_q[i-1];
      assign ip_in = ip_q[i-1];
      assign z_in  = sz_q[i-1];
    end
    assign sq = y_in * y_in;
    assign t  = sq[MANT_FRAC +: MANT_W+1];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t[MANT_W]) begin
          y_q[i]  <= t[MANT_W:1];
          fr_q[i] <= {fr_in[LOG_FRAC-2:0], 1'b1};
        end else begin
          y_q[i]  <= t[MANT_W-1:0];
          fr_q[i] <= {fr_in[LOG_FRAC-2:0], 1'b0};
        end
        ip_q[i] <= ip_in;
        sz_q[i] <= z_in;
      end
    end
  end

  // A zero argument counts as ln 1.
  assign log_o = sz_q[LOG_FRAC-1] ? '0 : {ip_q[LOG_FRAC-1], fr_q[LOG_FRAC-1]};

endmodule

/* design/sfd_scale.sv */
// ---------------------------------------------------------------------------
// sfd_scale: log difference, ln2 scaling and numerator build
// Four stages turn two base-2 logs into the dividend and divisor of the
// final rounded division.
// ---------------------------------------------------------------------------
module sfd_scale import sfd_pkg::*; #(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  localparam int LGW  = lg_width(TIME_WIDTH, FRAC_BITS),
  localparam int NUMW = TIME_WIDTH + 1,
  localparam int NW   = n_width(TIME_WIDTH, FRAC_BITS),
  localparam int DDW  = d_width(TIME_WIDTH, FRAC_BITS)
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [LGW-1:0] log_u_i,
  input  logic signed [LGW-1:0] log_w_i,
  input  logic [NUMW-1:0]       num_i,
  input  logic [TIME_WIDTH-1:0] len_i,
  output logic [NW-1:0]         dividend_o,
  output logic [DDW-1:0]        divisor_o,
  output logic                  neg_o
);

  localparam int DW  = LGW + 1;
  localparam int LNW = ln_width(TIME_WIDTH, FRAC_BITS);
  localparam int H   = (NUMW + 1) / 2;
  localparam int HI  = NUMW - H;
  localparam int PW  = NUMW + LNW;
  localparam int SHP = sh_pos(FRAC_BITS);
  localparam int SHN = sh_neg(FRAC_BITS);
  localparam int RW  = DW + LN2_W + 1;

  // Stage 1: signed difference and its magnitude.
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        s1_mag_q;
  logic                 s1_neg_q;
  logic [NUMW-1:0]      s1_num_q;
  logic [TIME_WIDTH-1:0] s1_len_q;

  assign diff = DW'(log_u_i) - DW'(log_w_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_neg_q <= diff[DW-1];
      s1_mag_q <= diff[DW-1] ? DW'(-diff) : DW'(diff);
      s1_num_q <= num_i;
      s1_len_q <= len_i;
    end
  end

  // Stage 2: times ln2, rounded half up to the ln fraction.
  logic [RW-1:0]         lnp;
  logic [LNW-1:0]        s2_ln_q;
  logic                  s2_neg_q;
  logic [NUMW-1:0]       s2_num_q;
  logic [TIME_WIDTH-1:0] s2_len_q;

  assign lnp = RW'(s1_mag_q * LN2_Q24) + (RW'(1) << (LN_DROP - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_ln_q  <= lnp[LN_DROP +: LNW];
      s2_neg_q <= s1_neg_q;
      s2_num_q <= s1_num_q;
      s2_len_q <= s1_len_q;
    end
  end

  // Stage 3: two partial products of the numerator.
  logic [H+LNW-1:0]      s3_p0_q;
  logic [HI+LNW-1:0]     s3_p1_q;
  logic                  s3_neg_q;
  logic [TIME_WIDTH-1:0] s3_len_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_p0_q  <= s2_num_q[H-1:0] * s2_ln_q;
      s3_p1_q  <= s2_num_q[NUMW-1:H] * s2_ln_q;
      s3_neg_q <= s2_neg_q;
      s3_len_q <= s2_len_q;
    end
  end

  // Stage 4: full product, rounding term and divisor.
  logic [PW-1:0]  prod;
  logic [NW-1:0]  s4_n_q;
  logic [DDW-1:0] s4_d_q;
  logic           s4_neg_q;

  assign prod = PW'(s3_p0_q) + (PW'(s3_p1_q) << H);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_n_q   <= (NW'(prod) << SHN) + (NW'(s3_len_q) << (1 + SHP));
      s4_d_q   <= DDW'(s3_len_q) << (2 + SHP);
      s4_neg_q <= s3_neg_q;
    end
  end

  assign dividend_o = s4_n_q;
  assign divisor_o  = s4_d_q;
  assign neg_o      = s4_neg_q;

endmodule

/* design/sfd_divider.sv */
// ---------------------------------------------------------------------------
// sfd_divider: pipelined restoring divider
// An overflow check stage and then one quotient bit per stage.
// ---------------------------------------------------------------------------
module sfd_divider import sfd_pkg::*; #(
  parameter int NW  = 64,
  parameter int DDW = 36
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [NW-1:0]      dividend_i,
  input  logic [DDW-1:0]     divisor_i,
  output logic [VALUE_W-1:0] quot_o,
  output logic               ovf_o
);

  localparam int CW = ((NW > DDW + VALUE_W) ? NW : DDW + VALUE_W) + 1;

  logic [CW-1:0]      r0_q;
  logic [DDW-1:0]     d0_q;
  logic               o0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q <= CW'(dividend_i);
      d0_q <= divisor_i;
      o0_q <= CW'(dividend_i) >= (CW'(divisor_i) << VALUE_W);
    end
  end

  logic [CW-1:0]      r_q [VALUE_W];
  logic [DDW-1:0]     d_q [VALUE_W];
  logic [VALUE_W-1:0] q_q [VALUE_W];
  logic               o_q [VALUE_W];

  for (genvar j = 0; j < VALUE_W; j++) begin : g_bit
    localparam int SH = VALUE_W - 1 - j;
    logic [CW-1:0]      r_in;
    logic [DDW-1:0]     d_in;
    logic [VALUE_W-1:0] q_in;
    logic               o_in;
    logic [CW-1:0]      ds;
    if (j == 0) begin : g_first
      assign r_in = r0_q;
      assign d_in = d0_q;
      assign q_in = '0;
      assign o_in = o0_q;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign d_in = d_q[j-1];
      assign q_in = q_q[j-1];
      assign o_in = o_q[j-1];
    end
    assign ds = CW'(d_in) << SH;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r_in >= ds) begin
          r_q[j] <= r_in - ds;
          q_q[j] <= {q_in[VALUE_W-2:0], 1'b1};
        end else begin
          r_q[j] <= r_in;
          q_q[j] <= {q_in[VALUE_W-2:0], 1'b0};
        end
        d_q[j] <= d_in;
        o_q[j] <= o_in;
      end
    end
  end

  assign quot_o = q_q[VALUE_W-1];
  assign ovf_o  = o_q[VALUE_W-1];

endmodule

/* design/spike_future_dissimilarity.sv */
// ---------------------------------------------------------------------------
// spike_future_dissimilarity: future part of a bivariate spike distance
// One train pair and one interval per word, one signed fixed-point
// dissimilarity and a status code per result word.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake                  | Word
//  --------+----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o    | spike, distance and interval times
//  out     | out_valid_o / out_stall_i  | value_o, status_o
//
// A new word is taken in every cycle while no result is stalled. The
// path runs through the front stage, the two log pipelines (normaliser
// plus one squaring stage per log fraction bit), the scaling stages, the
// restoring divider (one quotient bit per stage) and the output register.
// Reset clears only the valid bits. A stalled result freezes the whole
// pipeline at once, and the input is stalled in the same cycle, so no word
// is lost or repeated.
//
module spike_future_dissimilarity import sfd_pkg::*; #(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [TIME_WIDTH-1:0]     spike_a_i,
  input  logic [TIME_WIDTH-1:0]     spike_b_i,
  input  logic [TIME_WIDTH-1:0]     dist_a_i,
  input  logic [TIME_WIDTH-1:0]     dist_b_i,
  input  logic [TIME_WIDTH-1:0]     interval_start_i,
  input  logic [TIME_WIDTH-1:0]     interval_end_i,
  input  logic [TIME_WIDTH-1:0]     interval_length_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic [STATUS_W-1:0]       status_o
);

  localparam int VW     = TIME_WIDTH + 1;
  localparam int LGW    = lg_width(TIME_WIDTH, FRAC_BITS);
  localparam int NW     = n_width(TIME_WIDTH, FRAC_BITS);
  localparam int DDW    = d_width(TIME_WIDTH, FRAC_BITS);
  localparam int LOGLAT = $clog2(VW) + LOG_FRAC;
  localparam int SCLAT  = 4;
  localparam int DIVLAT = VALUE_W + 1;
  localparam int AW     = CTRL_W + VW + TIME_WIDTH;

  // The whole pipeline moves as one; it holds only while a result waits.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Front stage: ordering, doubled log arguments and the special cases.
  logic [VW-1:0] sum, e2, s2, arg_u, arg_w, num;
  logic          a_later, eq, lenz, negarg;
  sfd_ctrl_t     ctrl_d;

  always_comb begin
    sum     = VW'(spike_a_i) + VW'(spike_b_i);
    e2      = {interval_end_i, 1'b0};
    s2      = {interval_start_i, 1'b0};
    arg_u   = sum - e2;
    arg_w   = sum - s2;
    a_later = spike_a_i > spike_b_i;
    eq      = spike_a_i == spike_b_i;
    lenz    = interval_length_i == '0;
    negarg  = (e2 > sum) || (s2 > sum);
    if (a_later) begin
      num = VW'(spike_a_i - spike_b_i) + VW'(dist_a_i);
    end else begin
      num = VW'(spike_b_i - spike_a_i) + VW'(dist_b_i);
    end
    ctrl_d.zero = eq || lenz || negarg;
    if (eq) begin
      ctrl_d.code = ST_OK;
    end else if (lenz) begin
      ctrl_d.code = ST_ZERO_LEN;
    end else if (negarg) begin
      ctrl_d.code = ST_RANGE;
    end else begin
      ctrl_d.code = ST_OK;
    end
  end

  logic                  f_valid_q;
  sfd_ctrl_t             f_ctrl_q;
  logic [VW-1:0]         f_u_q, f_w_q, f_num_q;
  logic [TIME_WIDTH-1:0] f_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ctrl_q <= ctrl_d;
      f_u_q    <= arg_u;
      f_w_q    <= arg_w;
      f_num_q  <= num;
      f_len_q  <= interval_length_i;
    end
  end

  // Two logs in parallel, with the side data delayed to match.
  logic signed [LGW-1:0] log_u, log_w;

  sfd_log2 #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_log_u (
    .clk_i (clk_i), .en_i (en), .arg_i (f_u_q), .log_o (log_u)
  );

  sfd_log2 #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_log_w (
    .clk_i (clk_i), .en_i (en), .arg_i (f_w_q), .log_o (log_w)
  );

  logic                  a_valid;
  logic [AW-1:0]         a_data;
  sfd_ctrl_t             a_ctrl;
  logic [VW-1:0]         a_num;
  logic [TIME_WIDTH-1:0] a_len;

  sfd_delay #(.W(AW), .DEPTH(LOGLAT)) u_dly_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid_q),
    .data_i  ({f_ctrl_q, f_num_q, f_len_q}),
    .valid_o (a_valid),
    .data_o  (a_data)
  );

  assign {a_ctrl, a_num, a_len} = a_data;

  // Scaling into dividend and divisor.
  logic [NW-1:0]  dividend;
  logic [DDW-1:0] divisor;
  logic           sc_neg;

  sfd_scale #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i      (clk_i),
    .en_i       (en),
    .log_u_i    (log_u),
    .log_w_i    (log_w),
    .num_i      (a_num),
    .len_i      (a_len),
    .dividend_o (dividend),
    .divisor_o  (divisor),
    .neg_o      (sc_neg)
  );

  logic          b_valid;
  logic [CTRL_W-1:0] b_data;

  sfd_delay #(.W(CTRL_W), .DEPTH(SCLAT)) u_dly_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid),
    .data_i  (a_ctrl),
    .valid_o (b_valid),
    .data_o  (b_data)
  );

  // Rounded division, with control and sign delayed alongside.
  logic [VALUE_W-1:0] quot;
  logic               ovf;

  sfd_divider #(.NW(NW), .DDW(DDW)) u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quot_o     (quot),
    .ovf_o      (ovf)
  );

  logic              c_valid;
  logic [CTRL_W:0]   c_data;
  sfd_ctrl_t         c_ctrl;
  logic              c_neg;

  sfd_delay #(.W(CTRL_W + 1), .DEPTH(DIVLAT)) u_dly_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid),
    .data_i  ({b_data, sc_neg}),
    .valid_o (c_valid),
    .data_o  (c_data)
  );

  assign {c_ctrl, c_neg} = c_data;

  // Sign, saturation and the special cases into the output register.
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic [VALUE_W-1:0] val_d;
  status_e            st_d;

  always_comb begin
    val_d = '0;
    st_d  = ST_OK;
    if (c_ctrl.zero) begin
      st_d = c_ctrl.code;
    end else if (!c_neg) begin
      // A rising log term gives a non-positive result.
      if (ovf || (quot[VALUE_W-1] && (quot[VALUE_W-2:0] != '0))) begin
        val_d = VAL_MIN;
        st_d  = ST_RANGE;
      end else begin
        val_d = -quot;
      end
    end else begin
      if (ovf || quot[VALUE_W-1]) begin
        val_d = VAL_MAX;
        st_d  = ST_RANGE;
      end else begin
        val_d = quot;
      end
    end
  end

  logic               o_valid_q;
  logic [VALUE_W-1:0] o_val_q;
  status_e            o_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (en) begin
      o_valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_val_q <= val_d;
      o_st_q  <= st_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign value_o     = o_val_q;
  assign status_o    = o_st_q;

endmodule

/* test/spike_future_dissimilarity_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spike_future_dissimilarity_tb: self-checking bench for the future dissimilarity block
// A short table of directed words is followed by random words, mostly well
// formed intervals, in three idling phases. Each result word is checked against its
// table answer or a bit-exact fixed-point predictor of the logarithm and divider.
// ---------------------------------------------------------------------------
module spike_future_dissimilarity_tb;
  import sfd_pkg::*;

  localparam int TW        = DEF_TIME_WIDTH;
  localparam int FB        = DEF_FRAC_BITS;
  localparam int N_RANDOM  = 1800;
  localparam int DRAIN     = 120;
  localparam int LIMIT     = 400000;

  // One input word as it is handed to the block.
  typedef struct packed {
    logic [TW-1:0] a;
    logic [TW-1:0] b;
    logic [TW-1:0] da;
    logic [TW-1:0] db;
    logic [TW-1:0] st;
    logic [TW-1:0] en;
    logic [TW-1:0] len;
  } spikes_t;

  // One result word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_e                   status;
  } dissim_t;

  // A row of the directed table: the word and, where it is obvious, its answer.
  typedef struct packed {
    spikes_t w;
    logic    known;
    dissim_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [VALUE_W-1:0] value_o;
  logic [STATUS_W-1:0] status_o;
  spikes_t drv = '0;

  dissim_t pending_results[$];
  int      failures = 0;
  int      n_checked = 0;
  int      n_sent = 0;
  int      cycles = 0;
  int      phase = 0;
  int      recv_idle_pct = 66;

  spike_future_dissimilarity u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .spike_a_i        (drv.a),
    .spike_b_i        (drv.b),
    .dist_a_i         (drv.da),
    .dist_b_i         (drv.db),
    .interval_start_i (drv.st),
    .interval_end_i   (drv.en),
    .interval_length_i(drv.len),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .value_o          (value_o),
    .status_o         (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // log2 of a doubled log argument in Q.32; the mantissa is kept as 1.30 and
  // each fraction bit comes from one truncated squaring.
  function automatic longint log2_fix(input longint unsigned v);
    int pos;
    longint unsigned y;
    longint unsigned frac;
    frac = 0;
    if (v == 0) return 0;
    pos = 63;
    while (v[pos] == 1'b0) pos--;
    if (pos >= MANT_FRAC) y = v >> (pos - MANT_FRAC);
    else                  y = v << (MANT_FRAC - pos);
    for (int i = 0; i < LOG_FRAC; i++) begin
      y = (y * y) >> MANT_FRAC;
      frac = frac << 1;
      if (y >= (64'd2 << MANT_FRAC)) begin
        y = y >> 1;
        frac = frac | 64'd1;
      end
    end
    return longint'(pos - (FB + 1)) * (64'sd1 <<< 32) + longint'(frac);
  endfunction

  // Expected result for one word.
  function automatic dissim_t future_dissim(input spikes_t w);
    dissim_t r;
    longint unsigned sum, e2, s2, later, earlier, dl, dmag, ln_mag, num, prod, div, mag;
    longint diff;
    bit neg;
    r.value = '0;
    r.status = ST_OK;
    if (w.a == w.b) return r;
    if (w.len == 0) begin
      r.status = ST_ZERO_LEN;
      return r;
    end
    if (w.a > w.b) begin
      later = w.a; earlier = w.b; dl = w.da;
    end else begin
      later = w.b; earlier = w.a; dl = w.db;
    end
    sum = longint'(w.a) + longint'(w.b);
    e2 = longint'(w.en) << 1;
    s2 = longint'(w.st) << 1;
    if (e2 > sum || s2 > sum) begin
      r.status = ST_RANGE;
      return r;
    end
    diff = log2_fix(sum - e2) - log2_fix(sum - s2);
    neg = diff < 0;
    dmag = neg ? longint'(-diff) : longint'(diff);
    ln_mag = (dmag * LN2_Q24 + (64'd1 << 35)) >> 36;
    num = later - earlier + dl;
    prod = num * ln_mag;
    div = (longint'(w.len) << 2) << (LN_FRAC - FB);
    mag = (prod + div / 2) / div;
    if (!neg) begin
      // A rising log gives a result at or below zero.
      if (mag > 64'h8000_0000) begin
        r.value = 32'h8000_0000;
        r.status = ST_RANGE;
      end else begin
        r.value = 32'(64'd0 - mag);
      end
    end else if (mag > 64'h7FFF_FFFF) begin
      r.value = 32'h7FFF_FFFF;
      r.status = ST_RANGE;
    end else begin
      r.value = 32'(mag);
    end
    return r;
  endfunction

  // Random word: mostly a well-formed interval below the spike mean, with
  // some words of fully random bits and some with equal spike times.
  function automatic spikes_t random_spikes();
    spikes_t w;
    longint unsigned m2;
    int mode;
    mode = $urandom_range(0, 9);
    w.a = $urandom; w.b = $urandom; w.da = $urandom; w.db = $urandom;
    w.st = $urandom; w.en = $urandom; w.len = $urandom;
    if (mode < 7) begin
      if (mode < 4) begin
        w.a = $urandom_range(0, 32'h00FF_FFFF);
        w.b = w.a + $urandom_range(1, 32'h000F_FFFF);
        w.da = $urandom_range(0, 32'h000F_FFFF);
        w.db = $urandom_range(0, 32'h000F_FFFF);
        w.len = $urandom_range(32'h100, 32'h00FF_FFFF);
      end
      if ($urandom_range(0, 1)) {w.a, w.b} = {w.b, w.a};
      m2 = (longint'(w.a) + longint'(w.b)) >> 1;
      w.st = 32'(m2 - (m2 == 0 ? 0 : ({$urandom, $urandom} % (m2 + 1))));
      w.en = 32'(m2 - (m2 == 0 ? 0 : ({$urandom, $urandom} % (m2 + 1))));
      if (mode == 6 && $urandom_range(0, 3) == 0) w.en = 32'(m2);
      if (mode == 5 && $urandom_range(0, 7) == 0) w.len = '0;
    end else if (mode == 8) begin
      w.b = w.a;
    end
    return w;
  endfunction

  // Valid stays high after an accepted word, so words can follow back to back;
  // it drops only while the sender idles or when the caller lowers it.
  task automatic send_word(input spikes_t w, input dissim_t res, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    drv <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(res);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Receiver stalls at random in the share that the current phase sets.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    dissim_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word value=%h status=%0d", $time, value_o, status_o);
        failures++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (value_o !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, value_o);
          failures++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          failures++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    spikes_t w;
    int send_idle_pct;
    int wait_cycles;
    localparam logic [TW-1:0] ONE = 32'h0001_0000;
    localparam logic [TW-1:0] MX = '1;

    // Directed table: equal times, zero length and negative arguments have
    // answers that can be read straight off; the rest go to the predictor.
    rows.push_back('{'{32'd0, 32'd0, MX, MX, MX, MX, MX}, 1'b1, '{32'sd0, ST_OK}});
    rows.push_back('{'{MX, MX, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{32'sd0, ST_OK}});
    rows.push_back('{'{ONE, 2*ONE, ONE, ONE, 32'd0, ONE, 32'd0}, 1'b1,
                     '{32'sd0, ST_ZERO_LEN}});
    rows.push_back('{'{ONE, 3*ONE, ONE, ONE, 32'd0, 3*ONE, ONE}, 1'b1,
                     '{32'sd0, ST_RANGE}});
    rows.push_back('{'{ONE, 3*ONE, ONE, ONE, 3*ONE, 32'd0, ONE}, 1'b1,
                     '{32'sd0, ST_RANGE}});
    rows.push_back('{'{MX, 32'd0, MX, MX, MX, MX, MX}, 1'b1, '{32'sd0, ST_RANGE}});
    // Zero log argument at the end, then at the start.
    rows.push_back('{'{ONE, 3*ONE, ONE, 2*ONE, 32'd0, 2*ONE, ONE}, 1'b0, '0});
    rows.push_back('{'{3*ONE, ONE, 2*ONE, ONE, 2*ONE, 32'd0, ONE}, 1'b0, '0});
    // Ordinary intervals, both orders of the trains.
    rows.push_back('{'{ONE, 5*ONE, ONE, 2*ONE, 32'd0, ONE, ONE}, 1'b0, '0});
    rows.push_back('{'{5*ONE, ONE, 2*ONE, ONE, ONE, 32'd0, ONE}, 1'b0, '0});
    // Saturation both ways: huge distance over the smallest length.
    rows.push_back('{'{32'd0, MX, MX, MX, 32'd0, 32'h7FFF_0000, 32'd1}, 1'b0, '0});
    rows.push_back('{'{MX, 32'd0, MX, MX, 32'h7FFF_0000, 32'd0, 32'd1}, 1'b0, '0});
    rows.push_back('{'{32'd1, MX, 32'd0, MX, 32'd1, 32'd2, MX}, 1'b0, '0});
    rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                       32'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0});

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      send_word(rows[i].w, rows[i].known ? rows[i].res : future_dissim(rows[i].w), 0);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 33 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        w = random_spikes();
        send_word(w, future_dissim(w), send_idle_pct);
      end
      // Let the pipeline run dry before the next phase.
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk_i);
    end

    wait_cycles = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    while (wait_cycles < DRAIN) begin
      @(negedge clk_i);
      wait_cycles++;
    end

    $display("Sent %0d words (directed table and three idling phases), checked %0d results.",
             n_sent, n_checked);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
